@@ rtl/idq_pkg.sv @@
// Package with sizes, opcodes, status codes and control types of the indexed deque.
package idq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int COUNT_W    = ADDR_W + 1;
  localparam int DATA_WIDTH = 32;
  localparam int OP_W       = 3;
  localparam int POS_W      = 10;
  localparam int STATUS_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH_TAIL  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_READ_IDX   = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_IDX  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

@@ rtl/idq_ram.sv @@
// Generic single-port RAM with registered read.
module idq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/idq_ctrl.sv @@
// Controller state machine that sequences one request through the datapath.
module idq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output idq_pkg::ctrl_cmd_t cmd
);
  import idq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC:  state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state != S_IDLE);
  assign done     = (state == S_RESP);
  assign cmd.load = (state == S_IDLE) && start;
  assign cmd.exec = (state == S_EXEC);

endmodule

@@ rtl/idq_dp.sv @@
// Datapath: request registers, ring pointer and count, element RAM and result registers.
module idq_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  idq_pkg::ctrl_cmd_t             cmd,
  input  logic [idq_pkg::OP_W-1:0]       opcode,
  input  logic [idq_pkg::POS_W-1:0]      position,
  input  logic [idq_pkg::DATA_WIDTH-1:0] data_in,
  output logic [idq_pkg::DATA_WIDTH-1:0] read_data,
  output logic [idq_pkg::STATUS_W-1:0]   status,
  output logic [idq_pkg::COUNT_W-1:0]    element_count,
  output logic                           is_empty
);
  import idq_pkg::*;

  logic [OP_W-1:0]       op_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] din_q;

  logic [ADDR_W-1:0]  head;
  logic [ADDR_W-1:0]  head_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;

  logic [STATUS_W-1:0] st_next;
  logic [STATUS_W-1:0] st_q;
  logic [COUNT_W-1:0]  count_q;
  logic                rd_sel_next;
  logic                rd_sel_q;

  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_addr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic              full;
  logic              empty;
  logic              in_range;
  logic [ADDR_W-1:0] offset;
  logic [ADDR_W:0]   slot_sum;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W-1:0] head_dec;

  assign full     = (count == COUNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign in_range = (COUNT_W'(pos_q) < count);
  assign head_dec = (head == '0) ? ADDR_W'(CAPACITY - 1) : head - 1'b1;

  // Logical offset from the front; below the count for reads and index writes, equal to it for a tail push.
  always_comb begin
    unique case (op_q)
      OP_PUSH_TAIL:                offset = count[ADDR_W-1:0];
      OP_READ_BACK:                offset = ADDR_W'(count - 1'b1);
      OP_READ_IDX, OP_WRITE_IDX:   offset = ADDR_W'(pos_q);
      default:                     offset = '0;
    endcase
  end

  // Ring wrap takes one compare and subtract, since both terms lie below the capacity.
  assign slot_sum = {1'b0, head} + {1'b0, offset};
  assign slot     = (slot_sum >= (ADDR_W+1)'(CAPACITY)) ?
                    ADDR_W'(slot_sum - (ADDR_W+1)'(CAPACITY)) : slot_sum[ADDR_W-1:0];

  always_comb begin
    head_next   = head;
    count_next  = count;
    st_next     = ST_OK;
    rd_sel_next = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = slot;
    unique case (op_q)
      OP_PUSH_TAIL: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          ram_we     = cmd.exec;
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        ram_addr = head_dec;
        if (full) begin
          st_next = ST_FULL;
        end else begin
          ram_we     = cmd.exec;
          head_next  = head_dec;
          count_next = count + 1'b1;
        end
      end
      OP_READ_IDX: begin
        if (!in_range) begin
          st_next = ST_RANGE;
        end else begin
          ram_re      = cmd.exec;
          rd_sel_next = 1'b1;
        end
      end
      OP_WRITE_IDX: begin
        if (!in_range) begin
          st_next = ST_RANGE;
        end else begin
          ram_we = cmd.exec;
        end
      end
      OP_READ_FRONT, OP_READ_BACK: begin
        if (empty) begin
          st_next = ST_EMPTY;
        end else begin
          ram_re      = cmd.exec;
          rd_sel_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      pos_q <= position;
      din_q <= data_in;
    end
    if (cmd.exec) begin
      st_q    <= st_next;
      count_q <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      rd_sel_q <= 1'b0;
    end else if (cmd.exec) begin
      head     <= head_next;
      count    <= count_next;
      rd_sel_q <= rd_sel_next;
    end
  end

  idq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (din_q),
    .rdata (ram_rdata)
  );

  assign read_data     = rd_sel_q ? ram_rdata : '0;
  assign status        = st_q;
  assign element_count = count_q;
  assign is_empty      = (count_q == '0);

endmodule

@@ rtl/indexed_double_ended_queue_top.sv @@
// Top level of the indexed double-ended queue: controller plus datapath.
//
// A request is taken when start is high while busy is low. It then goes through the
// execute state, with at most one access to the element RAM and the head and count
// update, and the response state, in which the result from the RAM's registered read
// port and the status are shown with done high. busy is low again in the cycle after
// done, so a new request can start only once the last is through. The result ports are
// valid only while done is high, and the receiver must take the result in that cycle.
module indexed_double_ended_queue_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [idq_pkg::OP_W-1:0]       opcode,
  input  logic [idq_pkg::POS_W-1:0]      position,
  input  logic [idq_pkg::DATA_WIDTH-1:0] data_in,
  output logic                           done,
  output logic [idq_pkg::DATA_WIDTH-1:0] read_data,
  output logic [idq_pkg::STATUS_W-1:0]   status,
  output logic [idq_pkg::COUNT_W-1:0]    element_count,
  output logic                           is_empty
);
  import idq_pkg::*;

  ctrl_cmd_t cmd;

  idq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  idq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .opcode        (opcode),
    .position      (position),
    .data_in       (data_in),
    .read_data     (read_data),
    .status        (status),
    .element_count (element_count),
    .is_empty      (is_empty)
  );

endmodule
